@@ sv/pcm_downmix_linear_resampler_defines.svh @@
// Assertion macros shared by the resampler RTL.
`ifndef PCM_DOWNMIX_LINEAR_RESAMPLER_DEFINES_SVH
`define PCM_DOWNMIX_LINEAR_RESAMPLER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PDLR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PDLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pdlr_pkg.sv @@
// Shared widths, constants and channel codes for the resampler.
`timescale 1ns / 1ps
package pdlr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 2;
  localparam int RATE_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 14;
  localparam int NCNT_W   = 4;

  // idx * rate product and the Q16 position dividend
  localparam int PROD_W   = IDX_W + RATE_W;
  localparam int DIV_W    = PROD_W + FRAC_W;
  localparam int STEP_W   = $clog2(DIV_W);

  // shared multiplier operands: signed diff (17b), index or count by unsigned frac/rate (16b)
  localparam int MUL_A_W  = SAMPLE_W + 2;
  localparam int MUL_B_W  = RATE_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int MAX_FRAME_SAMPLES_DEF = 2304;
  localparam logic [RATE_W-1:0] SINK_RATE_RESET = 16'd16000;
  localparam logic [IDX_W-1:0]  OUT_INDEX_LIMIT = 14'd16383;
  localparam logic [NCNT_W-1:0] RES_CAP = 4'd8;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

  localparam logic [CH_W-1:0] CH_NONE   = 2'd0;
  localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

endpackage

@@ sv/pdlr_ifs.sv @@
// Valid/ready channel interfaces: input samples, results, configuration writes.
`timescale 1ns / 1ps

interface pdlr_smp_if import pdlr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CH_W-1:0]            channels;
  logic [RATE_W-1:0]          in_rate;
  logic                       frame_end;

  modport source (output valid, sample, channels, in_rate, frame_end, input ready);
  modport sink   (input valid, sample, channels, in_rate, frame_end, output ready);
endinterface

interface pdlr_res_if import pdlr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       run_last;

  modport source (output valid, out_sample, run_last, input ready);
  modport sink   (input valid, out_sample, run_last, output ready);
endinterface

interface pdlr_cfg_if import pdlr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/pcm_downmix_linear_resampler.sv @@
// Mono downmix and linear-interpolation rate converter, one sample per request.
// Per request: accept, then per interpolated output a multiply, a 46-step restoring
//   divide for the Q16 position, a blend multiply and an emit; a frame end adds the
//   padding-target divide and then the padding outputs, one by one.
// A new request is taken only in idle, once the last one is done; the divider
//   makes 1 bit/cycle. Reset (rst, sync, active high): sink_rate = 16000,
//   frame state cleared.
`timescale 1ns / 1ps
`include "pcm_downmix_linear_resampler_defines.svh"

module pcm_downmix_linear_resampler import pdlr_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pdlr_smp_if.sink   smp,
  pdlr_res_if.source res,
  pdlr_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS_MUL, ST_POS_LD, ST_POS_DIV, ST_POS_CHK, ST_EMIT_I,
    ST_COMMIT, ST_TGT_MUL, ST_TGT_LD, ST_TGT_DIV, ST_PAD, ST_CLEAR, ST_FINISH
  } state_t;

  state_t state;

  // config and frame state
  logic [RATE_W-1:0]          sink_rate;
  logic signed [SAMPLE_W-1:0] held_left;
  logic                       pair_phase;
  logic signed [SAMPLE_W-1:0] prev_mono;
  logic [CNT_W-1:0]           mono_count;
  logic [IDX_W-1:0]           next_out_index;

  // per-request registers
  logic signed [SAMPLE_W-1:0] m_q;
  logic                       have_q;
  logic [RATE_W-1:0]          rate_q;
  logic                       fe_q;
  logic [NCNT_W-1:0]          res_cnt;

  // shared multiplier and divider
  logic signed [MUL_P_W-1:0]  prod;
  logic [DIV_W-1:0]           dq;
  logic [RATE_W-1:0]          rem;
  logic [RATE_W-1:0]          den;
  logic [STEP_W-1:0]          step;

  // result staging: pending result and output register
  logic signed [SAMPLE_W-1:0] pend;
  logic                       pend_valid;
  logic                       res_valid;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_last;

  assign smp.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign res.valid      = res_valid;
  assign res.out_sample = res_sample;
  assign res.run_last   = res_last;

  logic smp_acc;
  assign smp_acc = smp.valid && smp.ready;

  // ---- accept-time downmix ----
  logic                       audio_ok;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   pair_adj;
  logic signed [SAMPLE_W-1:0] mono_dbl;
  logic signed [SAMPLE_W-1:0] m_new;
  logic                       have_new;

  assign audio_ok = (smp.channels != CH_NONE) && (smp.in_rate != '0) && (sink_rate != '0);
  assign pair_sum = {held_left[SAMPLE_W-1], held_left} + {smp.sample[SAMPLE_W-1], smp.sample};
  // truncate toward zero: bump negative sums before the shift
  assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};

  always_comb begin
    if (smp.sample[SAMPLE_W-1:SAMPLE_W-2] == 2'b01) begin
      mono_dbl = SAT_MAX;
    end else if (smp.sample[SAMPLE_W-1:SAMPLE_W-2] == 2'b10) begin
      mono_dbl = SAT_MIN;
    end else begin
      mono_dbl = {smp.sample[SAMPLE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (smp.channels == CH_STEREO) begin
      m_new    = pair_adj[SAMPLE_W:1];
      have_new = audio_ok && pair_phase;
    end else begin
      m_new    = mono_dbl;
      have_new = audio_ok;
    end
  end

  logic mono_room;
  logic [CNT_W-1:0] mono_next;
  assign mono_room = mono_count < CNT_W'(MAX_FRAME_SAMPLES);
  assign mono_next = mono_count + 1'b1;

  // ---- shared multiplier ----
  logic signed [SAMPLE_W:0]  diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;

  assign diff = {m_q[SAMPLE_W-1], m_q} - {prev_mono[SAMPLE_W-1], prev_mono};

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_POS_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-IDX_W){1'b0}}, next_out_index});
        mul_b  = $signed({1'b0, rate_q});
      end
      ST_POS_CHK: begin
        mul_en = 1'b1;
        mul_a  = {diff[SAMPLE_W], diff};
        mul_b  = $signed({1'b0, dq[FRAC_W-1:0]});
      end
      ST_TGT_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-CNT_W){1'b0}}, mono_count});
        mul_b  = $signed({1'b0, sink_rate});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // ---- divider step ----
  logic [RATE_W:0] div_t;
  logic            div_ge;
  logic [RATE_W:0] div_sub;
  assign div_t   = {rem, dq[DIV_W-1]};
  assign div_ge  = div_t >= {1'b0, den};
  assign div_sub = div_t - {1'b0, den};

  // ---- position check and blend ----
  logic [PROD_W:0] src_p2;
  logic            pos_past;
  assign src_p2   = {1'b0, dq[DIV_W-1:FRAC_W]} + (PROD_W+1)'(2);
  assign pos_past = src_p2 > (PROD_W+1)'(mono_next);

  logic signed [MUL_P_W-1:0]   blend_sum;
  logic signed [MUL_P_W-FRAC_W-1:0] blend_sh;
  logic signed [SAMPLE_W-1:0]  blend_val;
  assign blend_sum = $signed({{(MUL_P_W-SAMPLE_W-FRAC_W){prev_mono[SAMPLE_W-1]}},
                              prev_mono, {FRAC_W{1'b0}}}) + prod;
  assign blend_sh  = blend_sum[MUL_P_W-1:FRAC_W];

  always_comb begin
    if (blend_sh > (MUL_P_W-FRAC_W)'(SAT_MAX)) begin
      blend_val = SAT_MAX;
    end else if (blend_sh < (MUL_P_W-FRAC_W)'(SAT_MIN)) begin
      blend_val = SAT_MIN;
    end else begin
      blend_val = blend_sh[SAMPLE_W-1:0];
    end
  end

  // ---- loop conditions ----
  logic slot_free;
  logic can_put;
  logic room;
  logic pad_due;
  logic res_load;
  assign slot_free = !res_valid || res.ready;
  assign can_put   = !pend_valid || slot_free;
  assign room      = (res_cnt != RES_CAP) && (next_out_index != OUT_INDEX_LIMIT);
  // target is max(1, quotient)
  assign pad_due   = ({{(DIV_W-IDX_W){1'b0}}, next_out_index} < dq) ||
                     ((dq == '0) && (next_out_index == '0));
  // pending result moves into the output register
  assign res_load  = pend_valid && slot_free &&
                     ((state == ST_EMIT_I) || (state == ST_FINISH) ||
                      (state == ST_PAD && room && pad_due));

  logic [CNT_W-1:0] count_after;
  assign count_after = (have_q && mono_room) ? mono_next : mono_count;

  logic frame_idle;
  assign frame_idle = (mono_count == '0) && !pair_phase && (next_out_index == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sink_rate      <= SINK_RATE_RESET;
      held_left      <= '0;
      pair_phase     <= 1'b0;
      prev_mono      <= '0;
      mono_count     <= '0;
      next_out_index <= '0;
      res_cnt        <= '0;
      pend_valid     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        sink_rate <= cfg.data;
      end
      if (mul_en) begin
        prod <= mul_a * mul_b;
      end

      unique case (state)
        ST_IDLE: begin
          if (smp_acc) begin
            m_q     <= m_new;
            have_q  <= have_new;
            rate_q  <= smp.in_rate;
            fe_q    <= smp.frame_end;
            res_cnt <= '0;
            if (audio_ok) begin
              if (smp.channels == CH_STEREO && !pair_phase) begin
                held_left  <= smp.sample;
                pair_phase <= 1'b1;
              end else begin
                pair_phase <= 1'b0;
              end
            end
            if (have_new && mono_room && mono_count != '0) begin
              state <= ST_POS_MUL;
            end else begin
              state <= ST_COMMIT;
            end
          end
        end
        ST_POS_MUL: begin
          state <= room ? ST_POS_LD : ST_COMMIT;
        end
        ST_POS_LD: begin
          dq    <= {prod[PROD_W-1:0], {FRAC_W{1'b0}}};
          rem   <= '0;
          den   <= sink_rate;
          step  <= '0;
          state <= ST_POS_DIV;
        end
        ST_POS_DIV, ST_TGT_DIV: begin
          rem  <= div_ge ? div_sub[RATE_W-1:0] : div_t[RATE_W-1:0];
          dq   <= {dq[DIV_W-2:0], div_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_W - 1)) begin
            state <= (state == ST_POS_DIV) ? ST_POS_CHK : ST_PAD;
          end
        end
        ST_POS_CHK: begin
          state <= pos_past ? ST_COMMIT : ST_EMIT_I;
        end
        ST_EMIT_I: begin
          if (can_put) begin
            if (pend_valid) begin
              res_sample <= pend;
              res_last   <= 1'b0;
            end
            pend           <= blend_val;
            pend_valid     <= 1'b1;
            res_cnt        <= res_cnt + 1'b1;
            next_out_index <= next_out_index + 1'b1;
            state          <= ST_POS_MUL;
          end
        end
        ST_COMMIT: begin
          if (have_q && mono_room) begin
            prev_mono  <= m_q;
            mono_count <= mono_next;
          end
          if (!fe_q) begin
            state <= ST_FINISH;
          end else if (count_after != '0 && rate_q != '0 && sink_rate != '0) begin
            state <= ST_TGT_MUL;
          end else begin
            state <= ST_CLEAR;
          end
        end
        ST_TGT_MUL: begin
          state <= ST_TGT_LD;
        end
        ST_TGT_LD: begin
          dq    <= {{(DIV_W-PROD_W){1'b0}}, prod[PROD_W-1:0]};
          rem   <= '0;
          den   <= rate_q;
          step  <= '0;
          state <= ST_TGT_DIV;
        end
        ST_PAD: begin
          if (!(room && pad_due)) begin
            state <= ST_CLEAR;
          end else if (can_put) begin
            if (pend_valid) begin
              res_sample <= pend;
              res_last   <= 1'b0;
            end
            pend           <= prev_mono;
            pend_valid     <= 1'b1;
            res_cnt        <= res_cnt + 1'b1;
            next_out_index <= next_out_index + 1'b1;
          end
        end
        ST_CLEAR: begin
          held_left      <= '0;
          pair_phase     <= 1'b0;
          prev_mono      <= '0;
          mono_count     <= '0;
          next_out_index <= '0;
          state          <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            res_sample <= pend;
            res_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  `PDLR_ASSERT_ALWAYS(a_idle_no_pend, !smp.ready || !pend_valid, "open with result pending")
  `PDLR_ASSERT_ALWAYS(a_res_cap, res_cnt <= RES_CAP, "result count over cap")
  `PDLR_ASSERT_NEXT(a_frame_clear, state == ST_CLEAR, frame_idle, "frame state not cleared")

endmodule
